@@ hw/rtl/udprc_pkg.sv @@
`default_nettype none
package udprc_pkg;

  localparam int unsigned COUNT_W = 17;

  localparam logic [COUNT_W-1:0] HDR_BYTES = COUNT_W'(8);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [15:0]        UDP_PROTO = 16'h0011;

  // verdict codes
  localparam logic [1:0] VERDICT_OK      = 2'd0;
  localparam logic [1:0] VERDICT_SHORT   = 2'd1;
  localparam logic [1:0] VERDICT_BAD_LEN = 2'd2;
  localparam logic [1:0] VERDICT_CSUM    = 2'd3;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 56;

  // per-datagram totals handed from the byte stage to the verdict stage
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [15:0]        sum;
    logic [7:0]         hold;
    logic [15:0]        length;
    logic [15:0]        checksum;
    logic [15:0]        sport;
    logic [15:0]        dport;
  } udprc_snap_t;

  // end-around fold of a sum of up to four 16-bit words
  function automatic logic [15:0] fold18(input logic [17:0] s);
    logic [16:0] t;
    t = {1'b0, s[15:0]} + {15'b0, s[17:16]};
    return t[15:0] + {15'b0, t[16]};
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/udp_receive_checker_top.sv @@
`default_nettype none
// UDP receive checker.
// Input channel (in_*): one datagram byte per item, header first. in_tdata
// carries the byte plus the IPv4 source and destination addresses, which
// are used only on the first byte of a datagram. in_tlast marks the final
// byte; only that item produces a result.
// Output channel (out_*): one verdict item per datagram with the ports,
// payload length and a checksum-verified flag.
// Throughput: one byte per clock while results drain, with no gaps between
// datagrams. The per-byte work is at most one ones'-complement add into the
// running sum; the first byte loads the folded pseudo-header addresses.
// A datagram's last byte passes through the input register, then the
// per-datagram total register, then the result register.
// Reset (rst_n low, synchronous) clears all per-datagram state and empties
// the pipeline; the first accepted byte afterwards starts a new datagram.
// Stall: if out_tready is held low the pipeline fills behind the waiting
// result and in_tready drops; nothing is lost or repeated. Non-last bytes
// keep flowing while a result waits, until the next last byte needs the
// total register.
module udp_receive_checker_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output      logic                                 in_tready,
  // [7:0] data_byte, [39:8] source_address, [71:40] dest_address
  input  wire logic [udprc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                                 in_tlast,
  output      logic                                 out_tvalid,
  input  wire logic                                 out_tready,
  // [1:0] verdict, [17:2] source_port, [33:18] dest_port,
  // [49:34] payload_length, [50] checksum_checked, [55:51] zero
  output      logic [udprc_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import udprc_pkg::*;

  // ---------------- input register ----------------
  logic                a_valid_r;
  logic [7:0]          a_byte_r;
  logic                a_last_r;
  logic [31:0]         a_src_r;
  logic [31:0]         a_dst_r;
  logic                a_adv;

  // ---------------- per-datagram state ----------------
  logic [COUNT_W-1:0]  count_r,  count_nxt;
  logic [15:0]         sum_r,    sum_nxt;
  logic [7:0]          hold_r,   hold_nxt;
  logic [15:0]         len_r,    len_nxt;
  logic [15:0]         csum_r,   csum_nxt;
  logic [15:0]         sport_r,  sport_nxt;
  logic [15:0]         dport_r,  dport_nxt;

  // ---------------- totals stage ----------------
  logic                b_valid_r;
  udprc_snap_t         b_snap_r;
  logic                b_load_ok;
  logic                b_adv;

  // ---------------- result register ----------------
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                out_load_ok;

  assign out_load_ok = !out_valid_r || out_tready;
  assign b_adv       = b_valid_r && out_load_ok;
  assign b_load_ok   = !b_valid_r || b_adv;
  // a non-last byte only touches the running state
  assign a_adv       = a_valid_r && (!a_last_r || b_load_ok);
  assign in_tready   = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_byte_r <= in_tdata[7:0];
      a_src_r  <= in_tdata[39:8];
      a_dst_r  <= in_tdata[71:40];
      a_last_r <= in_tlast;
    end
  end

  // ---------------- byte processing ----------------
  logic [17:0] addr_total;
  logic [7:0]  sum_byte;
  logic        in_sum_span;

  always_comb begin
    addr_total = {2'b0, a_src_r[31:16]} + {2'b0, a_src_r[15:0]}
               + {2'b0, a_dst_r[31:16]} + {2'b0, a_dst_r[15:0]};
    // checksum field bytes count as zero
    sum_byte    = (count_r == COUNT_W'(6) || count_r == COUNT_W'(7)) ? 8'h00 : a_byte_r;
    in_sum_span = (count_r < HDR_BYTES) || (count_r < {1'b0, len_r});

    count_nxt = (count_r < COUNT_MAX) ? count_r + COUNT_W'(1) : count_r;
    sum_nxt   = sum_r;
    hold_nxt  = hold_r;
    len_nxt   = len_r;
    csum_nxt  = csum_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;

    // running sum is always zero on the first byte, so the pseudo-header
    // addresses simply replace it
    if (count_r == '0) begin
      sum_nxt = fold18(addr_total);
    end

    unique case (count_r)
      COUNT_W'(0): sport_nxt = {a_byte_r, sport_r[7:0]};
      COUNT_W'(1): sport_nxt = {sport_r[15:8], a_byte_r};
      COUNT_W'(2): dport_nxt = {a_byte_r, dport_r[7:0]};
      COUNT_W'(3): dport_nxt = {dport_r[15:8], a_byte_r};
      COUNT_W'(4): len_nxt   = {a_byte_r, len_r[7:0]};
      COUNT_W'(5): len_nxt   = {len_r[15:8], a_byte_r};
      COUNT_W'(6): csum_nxt  = {a_byte_r, csum_r[7:0]};
      COUNT_W'(7): csum_nxt  = {csum_r[15:8], a_byte_r};
      default: ;
    endcase

    if (in_sum_span) begin
      if (!count_r[0]) begin
        hold_nxt = sum_byte;
      end else begin
        sum_nxt = fold18({2'b0, sum_r} + {2'b0, hold_r, sum_byte});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      len_r   <= '0;
      csum_r  <= '0;
      sport_r <= '0;
      dport_r <= '0;
    end else if (a_adv) begin
      if (a_last_r) begin
        count_r <= '0;
        sum_r   <= '0;
        hold_r  <= '0;
        len_r   <= '0;
        csum_r  <= '0;
        sport_r <= '0;
        dport_r <= '0;
      end else begin
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
        hold_r  <= hold_nxt;
        len_r   <= len_nxt;
        csum_r  <= csum_nxt;
        sport_r <= sport_nxt;
        dport_r <= dport_nxt;
      end
    end
  end

  // ---------------- totals register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_load_ok) begin
      b_valid_r <= a_adv && a_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load_ok && a_adv && a_last_r) begin
      b_snap_r.count    <= count_nxt;
      b_snap_r.sum      <= sum_nxt;
      b_snap_r.hold     <= hold_nxt;
      b_snap_r.length   <= len_nxt;
      b_snap_r.checksum <= csum_nxt;
      b_snap_r.sport    <= sport_nxt;
      b_snap_r.dport    <= dport_nxt;
    end
  end

  // ---------------- verdict ----------------
  logic [17:0] fin_total;
  logic [15:0] calc;
  logic        csum_match;
  logic [1:0]  verdict;
  logic [15:0] sp, dp, plen;
  logic        checked;

  always_comb begin
    // odd length: last byte padded with a zero low byte
    fin_total = {2'b0, b_snap_r.sum}
              + (b_snap_r.length[0] ? {2'b0, b_snap_r.hold, 8'h00} : 18'd0)
              + {2'b0, UDP_PROTO}
              + {2'b0, b_snap_r.length};
    calc       = ~fold18(fin_total);
    csum_match = (calc == b_snap_r.checksum)
              || (calc == 16'h0000 && b_snap_r.checksum == 16'hFFFF);

    verdict = VERDICT_OK;
    sp      = 16'h0000;
    dp      = 16'h0000;
    plen    = 16'h0000;
    checked = 1'b0;
    priority if (b_snap_r.count < HDR_BYTES) begin
      verdict = VERDICT_SHORT;
    end else if (b_snap_r.length < 16'd8 || {1'b0, b_snap_r.length} > b_snap_r.count) begin
      verdict = VERDICT_BAD_LEN;
      sp      = b_snap_r.sport;
      dp      = b_snap_r.dport;
    end else if (b_snap_r.checksum != 16'h0000 && !csum_match) begin
      verdict = VERDICT_CSUM;
      sp      = b_snap_r.sport;
      dp      = b_snap_r.dport;
    end else begin
      sp      = b_snap_r.sport;
      dp      = b_snap_r.dport;
      plen    = b_snap_r.length - 16'd8;
      checked = (b_snap_r.checksum != 16'h0000);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load_ok) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_data_r <= {5'b0, checked, plen, dp, sp, verdict};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
